@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files of the dead-reckoning block.
// Each macro clocks on clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// The property must hold at every clock edge outside reset.
`define WCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// The condition must never be seen outside reset.
`define WCD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

@@ design/wcd_pkg.sv @@
// Package for the dead-reckoning pose tracker: request codes, default sizes,
// the sine table generator and the saturation helpers. Depends on nothing.
package wcd_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int SINE_DEPTH_DEF = 1024;

  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    REQ_ODOM    = 2'd0,
    REQ_COMPASS = 2'd1,
    REQ_REVISE  = 2'd2,
    REQ_IMU     = 2'd3
  } req_e;

  // Sine of a Q2.30 radian angle in [0, 2*pi), Q2.14 result, Taylor series to x^15.
  function automatic logic signed [15:0] sin_q14(input logic [63:0] r_in);
    logic [63:0]        r;
    logic [63:0]        r2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    logic signed [15:0] m;
    logic               neg;
    r   = r_in;
    neg = 1'b0;
    if (r >= PI_Q30) begin
      r   = r - PI_Q30;
      neg = 1'b1;
    end
    if (r > HALF_PI_Q30) begin
      r = PI_Q30 - r;
    end
    r2   = (r * r) >> 30;
    term = r;
    sum  = signed'(r);
    term = ((term * r2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * r2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * r2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * r2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * r2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * r2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * r2) >> 30) / 64'd210;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    q = unsigned'((sum + 64'sd32768) >>> 16);
    if (q > 64'd16384) begin
      q = 64'd16384;
    end
    m = signed'(q[15:0]);
    return neg ? -m : m;
  endfunction

  // One table entry; the table depth is a power of two given by its log.
  function automatic logic signed [15:0] trig_entry(input int unsigned idx, input int log2d,
                                                    input logic cosine);
    logic [63:0] r;
    r = (64'(idx) * TWO_PI_Q30) >> log2d;
    if (cosine) begin
      r = r + HALF_PI_Q30;
      if (r >= TWO_PI_Q30) begin
        r = r - TWO_PI_Q30;
      end
    end
    return sin_q14(r);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] a);
    if (a > 64'sd32767) begin
      return 16'h7fff;
    end else if (a < -64'sd32768) begin
      return 16'h8000;
    end
    return a[15:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] a);
    if (a > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (a < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return a[31:0];
  endfunction

endpackage

@@ design/wheel_compass_dead_reckoning.sv @@
// Dead-reckoning pose tracker: odometer, compass, revise and IMU requests.
// Odometer requests pass through the trig, velocity and integrate states; compass requests
// integrate and, with a nonzero time step, then run the bit-serial divider; revise and IMU go to done.
// One request at a time: the next is taken only after the result is registered and the
// tracker is back in idle, so a stalled output also holds off the input.
// Asynchronous active-low reset clears the pose, velocities, turn rate and control.
module wheel_compass_dead_reckoning #(
  parameter int ANGLE_BITS       = wcd_pkg::ANGLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = wcd_pkg::SINE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [15:0] left_front_speed_i,
  input  logic signed [15:0] left_back_speed_i,
  input  logic signed [15:0] right_front_speed_i,
  input  logic signed [15:0] right_back_speed_i,
  input  logic [15:0]        time_step_i,
  input  logic [15:0]        new_heading_i,
  input  logic signed [31:0] new_x_i,
  input  logic signed [31:0] new_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [15:0]        heading_out_o,
  output logic signed [15:0] vel_x_o,
  output logic signed [15:0] vel_y_o,
  output logic signed [31:0] turn_rate_o,
  output logic               zero_time_fault_o
);

  // The sine table depth is taken to be a power of two.
  localparam int TBL_LOG2 = $clog2(SINE_TABLE_DEPTH);
  // Dividend of the turn rate: magnitude of the heading change times 65536.
  localparam int NUM_W    = ANGLE_BITS + 16;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int SH_UP    = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int SH_DN    = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TRIG  = 7'b0000010,
    S_VEL   = 7'b0000100,
    S_INTEG = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_RATE  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Pose state, cleared by reset.
  logic signed [31:0]    pos_x_q, pos_y_q;
  logic [ANGLE_BITS-1:0] head_q;
  logic signed [15:0]    vel_x_q, vel_y_q;
  logic signed [31:0]    rate_q;
  logic                  fault_q;
  logic                  out_valid_q;
  logic [CNT_W-1:0]      cnt_q;

  // Request payload captured at acceptance.
  wcd_pkg::req_e         type_q;
  logic signed [15:0]    v_q;
  logic [15:0]           dt_q;
  logic [ANGLE_BITS-1:0] nh_q;

  // Table outputs and the divider's shift registers.
  logic signed [15:0]    sin_q, cos_q;
  logic [NUM_W-1:0]      num_q;
  logic [NUM_W-1:0]      quo_q;
  logic [15:0]           rem_q;
  logic                  dneg_q;

  // Quarter-free sine and cosine tables, built at elaboration.
  logic signed [15:0] sin_rom [SINE_TABLE_DEPTH];
  logic signed [15:0] cos_rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sin_rom[g] = wcd_pkg::trig_entry(g, TBL_LOG2, 1'b0);
    assign cos_rom[g] = wcd_pkg::trig_entry(g, TBL_LOG2, 1'b1);
  end

  logic                  accept;
  logic                  out_load;
  logic [39:0]           head_wide;
  logic [ANGLE_BITS-1:0] head_in;
  logic signed [17:0]    wheel_sum;
  logic [63:0]           idx_wide;
  logic [TBL_LOG2-1:0]   tbl_idx;
  logic signed [31:0]    prod_x, prod_y;
  logic signed [32:0]    step_x, step_y;
  logic signed [63:0]    next_x, next_y;
  logic [ANGLE_BITS-1:0] head_diff;
  logic [ANGLE_BITS-1:0] head_mag;
  logic [16:0]           rem_sh;
  logic                  rem_ge;
  logic [NUM_W:0]        quo_ext;
  logic signed [63:0]    rate_wide;
  logic [39:0]           head_out_wide;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // A 16-bit heading is rescaled to the internal angle width.
  assign head_wide = (40'(new_heading_i) << SH_UP) >> SH_DN;
  assign head_in   = head_wide[ANGLE_BITS-1:0];

  // The mean of the four wheels: the two low bits of the sum drop off, which floors.
  assign wheel_sum = 18'(left_front_speed_i) + 18'(left_back_speed_i)
                   + 18'(right_front_speed_i) + 18'(right_back_speed_i);

  assign idx_wide = (64'(head_q) << TBL_LOG2) >> ANGLE_BITS;
  assign tbl_idx  = idx_wide[TBL_LOG2-1:0];

  // Velocity: the trig value times the mean speed, rounded back to Q8.8.
  assign prod_x = 32'(cos_q) * 32'(v_q);
  assign prod_y = 32'(sin_q) * 32'(v_q);

  // Position step: velocity times the time step, rounded into Q16.16.
  assign step_x = 33'(vel_x_q) * 33'(signed'({1'b0, dt_q}));
  assign step_y = 33'(vel_y_q) * 33'(signed'({1'b0, dt_q}));
  assign next_x = 64'(pos_x_q) + ((64'(step_x) + 64'sd128) >>> 8);
  assign next_y = 64'(pos_y_q) + ((64'(step_y) + 64'sd128) >>> 8);

  // Heading change wrapped to a signed angle; the divider works on its magnitude.
  assign head_diff = nh_q - head_q;
  assign head_mag  = head_diff[ANGLE_BITS-1] ? -head_diff : head_diff;

  // One restoring division step per cycle.
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dt_q};

  // The quotient is truncated toward zero, so the sign goes on after the magnitude.
  assign quo_ext   = {1'b0, quo_q};
  assign rate_wide = dneg_q ? -64'(signed'(quo_ext)) : 64'(signed'(quo_ext));

  assign head_out_wide = (40'(head_q) << SH_DN) >> SH_UP;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (wcd_pkg::req_e'(req_type_i))
            wcd_pkg::REQ_ODOM:    state_d = S_TRIG;
            wcd_pkg::REQ_COMPASS: state_d = S_INTEG;
            wcd_pkg::REQ_REVISE:  state_d = S_DONE;
            wcd_pkg::REQ_IMU:     state_d = S_DONE;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_TRIG:  state_d = S_VEL;
      S_VEL:   state_d = S_INTEG;
      S_INTEG: begin
        if (type_q == wcd_pkg::REQ_COMPASS && dt_q != 16'd0) begin
          state_d = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = S_RATE;
        end
      end
      S_RATE:  state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and pose state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      rate_q      <= '0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            fault_q <= 1'b0;
            if (wcd_pkg::req_e'(req_type_i) == wcd_pkg::REQ_REVISE) begin
              pos_x_q <= new_x_i;
              pos_y_q <= new_y_i;
              head_q  <= head_in;
            end
          end
        end
        S_VEL: begin
          vel_x_q <= signed'(wcd_pkg::sat16((64'(prod_x) + 64'sd8192) >>> 14));
          vel_y_q <= signed'(wcd_pkg::sat16((64'(prod_y) + 64'sd8192) >>> 14));
        end
        S_INTEG: begin
          pos_x_q <= signed'(wcd_pkg::sat32(next_x));
          pos_y_q <= signed'(wcd_pkg::sat32(next_y));
          cnt_q   <= '0;
          if (type_q == wcd_pkg::REQ_COMPASS) begin
            // The old heading is still used for the change this cycle.
            head_q <= nh_q;
            if (dt_q == 16'd0) begin
              fault_q <= 1'b1;
            end
          end
        end
        S_DIV:  cnt_q  <= cnt_q + CNT_W'(1);
        S_RATE: rate_q <= signed'(wcd_pkg::sat32(rate_wide));
        default: begin
        end
      endcase
    end
  end

  // Payload, table and divider registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q <= wcd_pkg::req_e'(req_type_i);
      v_q    <= wheel_sum[17:2];
      dt_q   <= time_step_i;
      nh_q   <= head_in;
    end
    if (state_q == S_TRIG) begin
      sin_q <= sin_rom[tbl_idx];
      cos_q <= cos_rom[tbl_idx];
    end
    if (state_q == S_INTEG) begin
      num_q  <= {head_mag, 16'd0};
      rem_q  <= '0;
      quo_q  <= '0;
      dneg_q <= head_diff[ANGLE_BITS-1];
    end
    if (state_q == S_DIV) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_ge ? 16'(rem_sh - {1'b0, dt_q}) : rem_sh[15:0];
      quo_q <= {quo_q[NUM_W-2:0], rem_ge};
    end
    if (out_load) begin
      pos_x_o           <= pos_x_q;
      pos_y_o           <= pos_y_q;
      heading_out_o     <= head_out_wide[15:0];
      vel_x_o           <= vel_x_q;
      vel_y_o           <= vel_y_q;
      turn_rate_o       <= rate_q;
      zero_time_fault_o <= fault_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ design/wcd_checker.sv @@
// Port checker for the dead-reckoning pose tracker, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module wcd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  `WCD_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy")
  `WCD_ASSERT(a_result_from_busy, $rose(out_valid_o) |-> $past(in_stall_o), "stray result")
  `WCD_ASSERT(a_result_holds, (out_valid_o && out_stall_i) |=> out_valid_o, "result dropped")

endmodule

bind wheel_compass_dead_reckoning wcd_checker u_wcd_checker (.*);

@@ test/wheel_compass_dead_reckoning_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the dead-reckoning pose tracker.
// Depends on wcd_pkg for the request codes and angle constants, and on the tracker itself.
module wheel_compass_dead_reckoning_test;

  // One request as offered to the tracker.
  typedef struct {
    wcd_pkg::req_e      kind;
    logic signed [15:0] lf;
    logic signed [15:0] lb;
    logic signed [15:0] rf;
    logic signed [15:0] rb;
    logic [15:0]        dt;
    logic [15:0]        hd;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
  } odo_req_t;

  // Pose and velocities as reported after one request.
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        hd;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [31:0] rate;
    logic               fault;
  } pose_t;

  // A row of the directed table; where typed is set the pose is written out by hand.
  typedef struct {
    odo_req_t req;
    logic     typed;
    pose_t    pose;
  } dir_row_t;

  localparam int NUM_RANDOM  = 630;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN       = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i = wcd_pkg::REQ_IMU;
  logic signed [15:0] left_front_speed_i = '0;
  logic signed [15:0] left_back_speed_i = '0;
  logic signed [15:0] right_front_speed_i = '0;
  logic signed [15:0] right_back_speed_i = '0;
  logic [15:0]        time_step_i = '0;
  logic [15:0]        new_heading_i = '0;
  logic signed [31:0] new_x_i = '0;
  logic signed [31:0] new_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic [15:0]        heading_out_o;
  logic signed [15:0] vel_x_o;
  logic signed [15:0] vel_y_o;
  logic signed [31:0] turn_rate_o;
  logic               zero_time_fault_o;

  wheel_compass_dead_reckoning u_dut (.*);

  // Predicted tracker state, kept alongside the real one.
  logic signed [31:0] track_x;
  logic signed [31:0] track_y;
  logic [15:0]        track_hd;
  logic signed [15:0] track_vx;
  logic signed [15:0] track_vy;
  logic signed [31:0] track_rate;

  pose_t    pending_poses[$];
  int       mismatches = 0;
  int       poses_seen = 0;
  int       cycles = 0;
  int       sent = 0;
  int       kind_count[4] = '{0, 0, 0, 0};
  logic     idling = 1'b1;
  logic     hold_req = 1'b0;
  dir_row_t dir_tab[14];

  // Sine of a Q2.30 radian angle in [0, 2*pi), folded into the first quadrant and
  // summed as a truncated Taylor series up to the fifteenth power, returned in Q2.14.
  function automatic logic signed [15:0] quadrant_sine(input logic [63:0] ang);
    logic [63:0]        a;
    logic [63:0]        a_sq;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        q;
    logic               negate;
    a      = ang;
    negate = 1'b0;
    if (a >= wcd_pkg::PI_Q30) begin
      a      = a - wcd_pkg::PI_Q30;
      negate = 1'b1;
    end
    if (a > wcd_pkg::HALF_PI_Q30) begin
      a = wcd_pkg::PI_Q30 - a;
    end
    a_sq = (a * a) >> 30;
    term = a;
    acc  = signed'(a);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * a_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = unsigned'((acc + 64'sd32768) >>> 16);
    if (q > 64'd16384) begin
      q = 64'd16384;
    end
    return negate ? -signed'(q[15:0]) : signed'(q[15:0]);
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] a,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    return a < lo ? lo : (a > hi ? hi : a);
  endfunction

  // Moves the position on by the held velocity over dt ticks of 1/65536 s.
  function automatic void dead_reckon(input logic [15:0] dt);
    logic signed [63:0] step_x;
    logic signed [63:0] step_y;
    step_x   = (64'(track_vx) * signed'(64'(dt)) + 64'sd128) >>> 8;
    step_y   = (64'(track_vy) * signed'(64'(dt)) + 64'sd128) >>> 8;
    track_x  = clamp(64'(track_x) + step_x, -64'sd2147483648, 64'sd2147483647);
    track_y  = clamp(64'(track_y) + step_y, -64'sd2147483648, 64'sd2147483647);
  endfunction

  // Applies one request to the predicted state and returns the pose it reports.
  function automatic pose_t track_request(input odo_req_t r);
    logic signed [63:0] speed;
    logic [63:0]        idx;
    logic [63:0]        ang;
    logic [63:0]        ang_c;
    logic signed [63:0] cosv;
    logic signed [63:0] sinv;
    logic signed [63:0] turn;
    logic signed [15:0] delta;
    pose_t              p;
    p.fault = 1'b0;
    case (r.kind)
      wcd_pkg::REQ_ODOM: begin
        speed = (64'(r.lf) + 64'(r.lb) + 64'(r.rf) + 64'(r.rb)) >>> 2;
        idx   = 64'(track_hd) >> 6;
        ang   = (idx * wcd_pkg::TWO_PI_Q30) >> 10;
        ang_c = ang + wcd_pkg::HALF_PI_Q30;
        if (ang_c >= wcd_pkg::TWO_PI_Q30) begin
          ang_c = ang_c - wcd_pkg::TWO_PI_Q30;
        end
        cosv     = 64'(quadrant_sine(ang_c));
        sinv     = 64'(quadrant_sine(ang));
        track_vx = 16'(clamp((cosv * speed + 64'sd8192) >>> 14, -64'sd32768, 64'sd32767));
        track_vy = 16'(clamp((sinv * speed + 64'sd8192) >>> 14, -64'sd32768, 64'sd32767));
        dead_reckon(r.dt);
      end
      wcd_pkg::REQ_COMPASS: begin
        dead_reckon(r.dt);
        if (r.dt == 0) begin
          p.fault = 1'b1;
        end else begin
          delta      = signed'(r.hd - track_hd);
          turn       = (64'(delta) * 64'sd65536) / signed'(64'(r.dt));
          track_rate = clamp(turn, -64'sd2147483648, 64'sd2147483647);
        end
        track_hd = r.hd;
      end
      wcd_pkg::REQ_REVISE: begin
        track_x  = r.nx;
        track_y  = r.ny;
        track_hd = r.hd;
      end
      default: begin
      end
    endcase
    p.px   = track_x;
    p.py   = track_y;
    p.hd   = track_hd;
    p.vx   = track_vx;
    p.vy   = track_vy;
    p.rate = track_rate;
    return p;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: pose %0d field %s expected %h, got %h", $realtime, poses_seen, field, want,
             got);
    mismatches++;
  endtask

  // Offers one request, holds it until accepted, then records the pose it should yield.
  task automatic offer(input odo_req_t r, input logic typed, input pose_t typed_pose);
    logic taken;
    if (idling && $urandom_range(99) < 30) begin
      repeat ($urandom_range(10, 1)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i          <= 1'b1;
    req_type_i          <= r.kind;
    left_front_speed_i  <= r.lf;
    left_back_speed_i   <= r.lb;
    right_front_speed_i <= r.rf;
    right_back_speed_i  <= r.rb;
    time_step_i         <= r.dt;
    new_heading_i       <= r.hd;
    new_x_i             <= r.nx;
    new_y_i             <= r.ny;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = in_valid_i && !in_stall_o;
    end
    if (typed) begin
      void'(track_request(r));
      pending_poses.push_back(typed_pose);
    end else begin
      pending_poses.push_back(track_request(r));
    end
    kind_count[r.kind]++;
    sent++;
  endtask

  function automatic odo_req_t random_request();
    odo_req_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.kind = wcd_pkg::REQ_ODOM;
    end else if (pick < 75) begin
      r.kind = wcd_pkg::REQ_COMPASS;
    end else if (pick < 90) begin
      r.kind = wcd_pkg::REQ_REVISE;
    end else begin
      r.kind = wcd_pkg::REQ_IMU;
    end
    // Mostly walking pace speeds so that the position does not pin at its limits.
    if ($urandom_range(9) < 8) begin
      r.lf = 16'(signed'($urandom_range(1024)) - 512);
      r.lb = 16'(signed'($urandom_range(1024)) - 512);
      r.rf = 16'(signed'($urandom_range(1024)) - 512);
      r.rb = 16'(signed'($urandom_range(1024)) - 512);
    end else begin
      r.lf = 16'($urandom);
      r.lb = 16'($urandom);
      r.rf = 16'($urandom);
      r.rb = 16'($urandom);
    end
    r.dt = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
    r.hd = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      r.nx = 32'($urandom);
      r.ny = 32'($urandom);
    end else begin
      r.nx = 32'(signed'($urandom_range(2000000)) - 1000000);
      r.ny = 32'(signed'($urandom_range(2000000)) - 1000000);
    end
    return r;
  endfunction

  // Clock, cycle count and the overall time limit.
  initial begin
    forever begin
      #6 clk_i = ~clk_i;
      if (clk_i) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
          $display("timed out after %0d cycles with %0d poses outstanding", cycles,
                   pending_poses.size());
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // Receiver side: random back-pressure, plus one long hold-off in its own count.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idling && ($urandom_range(99) < 10);
      end
    end
  end

  // Every accepted pose is compared, field by field, with the oldest prediction.
  always @(posedge clk_i) begin
    pose_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      poses_seen++;
      if (pending_poses.size() == 0) begin
        report("unexpected pose", 32'd0, 32'd1);
      end else begin
        want = pending_poses.pop_front();
        if (pos_x_o !== want.px) report("pos_x", want.px, pos_x_o);
        if (pos_y_o !== want.py) report("pos_y", want.py, pos_y_o);
        if (heading_out_o !== want.hd) report("heading_out", 32'(want.hd), 32'(heading_out_o));
        if (vel_x_o !== want.vx) report("vel_x", 32'(want.vx), 32'(vel_x_o));
        if (vel_y_o !== want.vy) report("vel_y", 32'(want.vy), 32'(vel_y_o));
        if (turn_rate_o !== want.rate) report("turn_rate", want.rate, turn_rate_o);
        if (zero_time_fault_o !== want.fault) begin
          report("zero_time_fault", 32'(want.fault), 32'(zero_time_fault_o));
        end
      end
    end
  end

  // Stimulus: the directed table first, then random requests, then the drain.
  initial begin
    odo_req_t r;
    pose_t    none;
    none = '{px: 0, py: 0, hd: 0, vx: 0, vy: 0, rate: 0, fault: 0};
    track_x = 0;
    track_y = 0;
    track_hd = 0;
    track_vx = 0;
    track_vy = 0;
    track_rate = 0;

    // Straight after reset an IMU request reports the cleared pose.
    dir_tab[0] = '{'{wcd_pkg::REQ_IMU, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'hffff,
                     16'hffff, 32'h7fffffff, 32'h80000000}, 1'b1, none};
    // Revise to the position extremes.
    dir_tab[1] = '{'{wcd_pkg::REQ_REVISE, 0, 0, 0, 0, 0, 16'hffff, 32'h7fffffff,
                     32'h80000000}, 1'b1,
                   '{32'h7fffffff, 32'h80000000, 16'hffff, 0, 0, 0, 1'b0}};
    // A compass request with no elapsed time flags, holds the rate and takes the heading.
    dir_tab[2] = '{'{wcd_pkg::REQ_COMPASS, 0, 0, 0, 0, 0, 16'h8000, 0, 0}, 1'b1,
                   '{32'h7fffffff, 32'h80000000, 16'h8000, 0, 0, 0, 1'b1}};
    // Full forward and full reverse speeds over the longest step, starting from the
    // position extremes.
    dir_tab[3] = '{'{wcd_pkg::REQ_ODOM, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff,
                     0, 0, 0}, 1'b0, none};
    dir_tab[4] = '{'{wcd_pkg::REQ_ODOM, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff,
                     0, 0, 0}, 1'b0, none};
    // Compass turns: the largest wrap, the shortest step and the longest one.
    dir_tab[5] = '{'{wcd_pkg::REQ_COMPASS, 0, 0, 0, 0, 16'd1, 16'h0000, 0, 0}, 1'b0, none};
    dir_tab[6] = '{'{wcd_pkg::REQ_COMPASS, 0, 0, 0, 0, 16'hffff, 16'h7fff, 0, 0}, 1'b0,
                   none};
    dir_tab[7] = '{'{wcd_pkg::REQ_COMPASS, 0, 0, 0, 0, 16'd3, 16'hffff, 0, 0}, 1'b0, none};
    // Odometer with no elapsed time updates only the velocities.
    dir_tab[8] = '{'{wcd_pkg::REQ_ODOM, 16'h0100, -16'sh0100, 16'h0203, 16'h7fff, 0, 0, 0,
                     0}, 1'b0, none};
    dir_tab[9] = '{'{wcd_pkg::REQ_REVISE, 0, 0, 0, 0, 16'h1234, 16'hc000, 32'h80000000,
                     32'h7fffffff}, 1'b0, none};
    dir_tab[10] = '{'{wcd_pkg::REQ_ODOM, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff,
                      0, 0, 0}, 1'b0, none};
    dir_tab[11] = '{'{wcd_pkg::REQ_IMU, 16'h1111, 16'h2222, 16'h4444, 16'h8888, 16'h5555,
                      16'haaaa, 32'h55555555, 32'haaaaaaaa}, 1'b0, none};
    dir_tab[12] = '{'{wcd_pkg::REQ_REVISE, 0, 0, 0, 0, 0, 16'h2000, 0, 0}, 1'b0, none};
    dir_tab[13] = '{'{wcd_pkg::REQ_ODOM, -16'sd300, 16'sd300, -16'sd77, 16'sd1000, 16'h4000,
                      0, 0, 0}, 1'b0, none};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      offer(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].pose);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // A quiet stretch with neither side idling, then one long receiver hold-off
      // while requests keep coming so that the tracker backs up into its input.
      idling = !(n >= 150 && n < 300);
      if (n == 350) begin
        hold_req = 1'b1;
      end
      r = random_request();
      offer(r, 1'b0, none);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_poses.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN) @(posedge clk_i);

    $display("Covered %0d requests: %0d odometer, %0d compass, %0d revise, %0d IMU.", sent,
             kind_count[wcd_pkg::REQ_ODOM], kind_count[wcd_pkg::REQ_COMPASS],
             kind_count[wcd_pkg::REQ_REVISE], kind_count[wcd_pkg::REQ_IMU]);
    $display("Checked %0d poses in %0d cycles, %0d field mismatches.", poses_seen, cycles,
             mismatches);
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/wcd_pkg.sv
design/wheel_compass_dead_reckoning.sv
design/wcd_checker.sv
test/wheel_compass_dead_reckoning_test.sv
